### sv/fms_pkg.sv
package fms_pkg;
	localparam int MAX_INPUTS_DEF = 16;
	localparam int MAX_OUTPUTS_DEF = 16;

	localparam logic [1:0] OP_INFLOW = 2'd0;
	localparam logic [1:0] OP_DEMAND = 2'd1;
	localparam logic [1:0] OP_COMPUTE = 2'd2;

	localparam logic [1:0] MODE_EQUAL = 2'd0;
	localparam logic [1:0] MODE_ROUTE = 2'd1;
	localparam logic [1:0] MODE_DEMAND = 2'd2;

	localparam logic [1:0] REG_NUM_INPUTS = 2'd0;
	localparam logic [1:0] REG_NUM_OUTPUTS = 2'd1;
	localparam logic [1:0] REG_MIX_MODE = 2'd2;
	localparam logic [1:0] REG_ROUTE_OUTPUT = 2'd3;

	localparam int MASS_W = 28;
	localparam int WSUM_W = 48;
	localparam int TSUM_W = 46;
	localparam int DIV_W = 52;
	localparam int QDIV_W = 6;

	// controller to datapath
	typedef struct packed {
		logic accum;
		logic store_demand;
		logic clear;
		logic div_start;
		logic [2:0] div_sel;
		logic load_res;
	} fms_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
	} fms_sts_t;

	localparam logic [2:0] DSEL_U = 3'd0;
	localparam logic [2:0] DSEL_A = 3'd1;
	localparam logic [2:0] DSEL_T = 3'd2;
	localparam logic [2:0] DSEL_FLOW = 3'd3;
endpackage

### sv/fms_div.sv
// restoring divider, one quotient bit per cycle, unsigned magnitudes
module fms_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [fms_pkg::DIV_W-1:0]        dividend,
	input  logic [fms_pkg::MASS_W-1:0]       divisor,
	output logic [fms_pkg::DIV_W-1:0]        quotient,
	output logic                             done
);
	localparam int W = fms_pkg::DIV_W;
	logic [W-1:0] quo_q;
	logic [fms_pkg::MASS_W:0] rem_q;
	logic [fms_pkg::MASS_W-1:0] dvs_q;
	logic [fms_pkg::QDIV_W-1:0] cnt_q;
	logic busy_q;
	logic [fms_pkg::MASS_W:0] trial;
	logic [fms_pkg::MASS_W:0] shifted;

	assign shifted = {rem_q[fms_pkg::MASS_W-1:0], quo_q[W-1]};
	assign trial = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= fms_pkg::QDIV_W'(W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[fms_pkg::MASS_W]) begin
				rem_q <= trial;
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule

### sv/fms_datapath.sv
module fms_datapath #(
	parameter int MAX_OUTPUTS = fms_pkg::MAX_OUTPUTS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  fms_pkg::fms_cmd_t      cmd,
	output fms_pkg::fms_sts_t      sts,
	input  logic [23:0]            flow_rate,
	input  logic [19:0]            conc_uranium,
	input  logic [19:0]            conc_acid,
	input  logic signed [17:0]     temperature,
	input  logic [23:0]            demand,
	input  logic [$clog2(MAX_OUTPUTS+1)-1:0] demand_idx,
	input  logic [$clog2(MAX_OUTPUTS+1)-1:0] out_idx,
	input  logic [$clog2(MAX_OUTPUTS+1)-1:0] nout,
	input  logic [$clog2(MAX_OUTPUTS+1)-1:0] demand_count,
	input  logic [1:0]             mix_mode,
	input  logic [3:0]             route_output,
	output logic [23:0]            res_flow,
	output logic [19:0]            res_u,
	output logic [19:0]            res_a,
	output logic [17:0]            res_t,
	output logic [23:0]            res_total
);
	localparam int AW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
	localparam int MW = fms_pkg::MASS_W;

	logic [MW-1:0] mass_q, dsum_q;
	logic [fms_pkg::WSUM_W-1:0] usum_q, asum_q;
	logic signed [fms_pkg::TSUM_W-1:0] tsum_q;
	logic [23:0] dmem [MAX_OUTPUTS];
	logic [23:0] drd_q;
	logic [19:0] mu_q, ma_q;
	logic [17:0] mt_q;
	logic [43:0] fu_p, fa_p;
	logic signed [42:0] ft_p;
	logic [MW+23:0] md_q;
	logic [fms_pkg::DIV_W-1:0] dividend, quotient;
	logic [MW-1:0] divisor;
	logic tneg;
	logic [fms_pkg::TSUM_W-1:0] tmag;
	logic [17:0] tq;
	logic [23:0] flow;
	logic carry;

	assign fu_p = flow_rate * conc_uranium;
	assign fa_p = flow_rate * conc_acid;
	assign ft_p = $signed({1'b0, flow_rate}) * temperature;
	assign tneg = tsum_q[fms_pkg::TSUM_W-1];
	assign tmag = tneg ? fms_pkg::TSUM_W'(-tsum_q) : fms_pkg::TSUM_W'(tsum_q);
	assign tq = tneg ? 18'(-quotient) : quotient[17:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q <= '0;
			dsum_q <= '0;
			usum_q <= '0;
			asum_q <= '0;
			tsum_q <= '0;
		end else if (cmd.clear) begin
			mass_q <= '0;
			dsum_q <= '0;
			usum_q <= '0;
			asum_q <= '0;
			tsum_q <= '0;
		end else begin
			if (cmd.accum) begin
				mass_q <= mass_q + MW'(flow_rate);
				usum_q <= usum_q + fms_pkg::WSUM_W'(fu_p);
				asum_q <= asum_q + fms_pkg::WSUM_W'(fa_p);
				tsum_q <= tsum_q + fms_pkg::TSUM_W'(ft_p);
			end
			if (cmd.store_demand)
				dsum_q <= dsum_q + MW'(demand);
		end
	end

	// demand memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.store_demand)
			dmem[demand_idx[AW-1:0]] <= demand;
		drd_q <= dmem[out_idx[AW-1:0]];
		md_q <= mass_q * ((out_idx < demand_count) ? drd_q : 24'd0);
	end

	always_comb begin
		case (cmd.div_sel)
			fms_pkg::DSEL_U: begin
				dividend = fms_pkg::DIV_W'(usum_q);
				divisor = mass_q;
			end
			fms_pkg::DSEL_A: begin
				dividend = fms_pkg::DIV_W'(asum_q);
				divisor = mass_q;
			end
			fms_pkg::DSEL_T: begin
				dividend = fms_pkg::DIV_W'(tmag);
				divisor = mass_q;
			end
			fms_pkg::DSEL_FLOW: begin
				if (mix_mode == fms_pkg::MODE_EQUAL) begin
					dividend = fms_pkg::DIV_W'(mass_q);
					divisor = MW'(nout);
				end else begin
					dividend = fms_pkg::DIV_W'(md_q);
					divisor = dsum_q;
				end
			end
			default: begin
				dividend = '0;
				divisor = '0;
			end
		endcase
	end

	fms_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(dividend), .divisor(divisor),
		.quotient(quotient), .done(sts.div_done)
	);

	always_ff @(posedge clk) begin
		if (sts.div_done) begin
			case (cmd.div_sel)
				fms_pkg::DSEL_U: mu_q <= (mass_q == '0) ? '0 : quotient[19:0];
				fms_pkg::DSEL_A: ma_q <= (mass_q == '0) ? '0 : quotient[19:0];
				fms_pkg::DSEL_T: mt_q <= (mass_q == '0) ? '0 : tq;
				default: ;
			endcase
		end
	end

	always_comb begin
		flow = '0;
		carry = 1'b0;
		case (mix_mode)
			fms_pkg::MODE_EQUAL: begin
				flow = (quotient > 52'hFFFFFF) ? 24'hFFFFFF : quotient[23:0];
				carry = 1'b1;
			end
			fms_pkg::MODE_ROUTE: begin
				if ({1'b0, route_output} < 5'(nout) && 5'(out_idx) == {1'b0, route_output}) begin
					flow = (mass_q > 28'hFFFFFF) ? 24'hFFFFFF : mass_q[23:0];
					carry = 1'b1;
				end
			end
			fms_pkg::MODE_DEMAND: begin
				if (dsum_q != '0) begin
					flow = (quotient > 52'hFFFFFF) ? 24'hFFFFFF : quotient[23:0];
					carry = flow != '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			res_flow <= flow;
			res_u <= carry ? mu_q : '0;
			res_a <= carry ? ma_q : '0;
			res_t <= carry ? mt_q : '0;
			res_total <= (mix_mode != fms_pkg::MODE_DEMAND) ? '0 :
				(dsum_q > 28'hFFFFFF) ? 24'hFFFFFF : dsum_q[23:0];
		end
	end
endmodule

### sv/fms_ctrl.sv
module fms_ctrl #(
	parameter int MAX_INPUTS = fms_pkg::MAX_INPUTS_DEF,
	parameter int MAX_OUTPUTS = fms_pkg::MAX_OUTPUTS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_fire,
	input  logic [1:0]             op,
	input  logic [4:0]             num_inputs,
	input  logic [4:0]             num_outputs,
	input  logic [1:0]             mix_mode,
	input  logic                   out_take,
	input  fms_pkg::fms_sts_t      sts,
	output fms_pkg::fms_cmd_t      cmd,
	output logic                   in_ready,
	output logic                   out_valid,
	output logic                   out_last,
	output logic [$clog2(MAX_OUTPUTS+1)-1:0] demand_count,
	output logic [$clog2(MAX_OUTPUTS+1)-1:0] out_idx,
	output logic [$clog2(MAX_OUTPUTS+1)-1:0] nout
);
	localparam int IW = $clog2(MAX_INPUTS + 1);
	localparam int CW = $clog2(MAX_OUTPUTS + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MEAN = 3'd1;
	localparam logic [2:0] ST_RD = 3'd2;
	localparam logic [2:0] ST_FLOW = 3'd3;
	localparam logic [2:0] ST_LOAD = 3'd4;
	localparam logic [2:0] ST_OUT = 3'd5;

	logic [2:0] state_q;
	logic [IW-1:0] in_cnt_q;
	logic [CW-1:0] dcnt_q, idx_q;
	logic [2:0] sel_q;
	logic [1:0] rd_q;
	logic busy_q, valid_q;
	logic [IW-1:0] nin;

	assign nin = (num_inputs == '0) ? IW'(1) :
		(int'(num_inputs) > MAX_INPUTS) ? IW'(MAX_INPUTS) : IW'(num_inputs);
	assign nout = (num_outputs == '0) ? CW'(1) :
		(int'(num_outputs) > MAX_OUTPUTS) ? CW'(MAX_OUTPUTS) : CW'(num_outputs);

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = valid_q;
	assign out_last = (idx_q + 1'b1) == nout;
	assign demand_count = dcnt_q;
	assign out_idx = idx_q;

	always_comb begin
		cmd = '0;
		cmd.div_sel = sel_q;
		cmd.accum = in_fire && op == fms_pkg::OP_INFLOW && in_cnt_q < nin;
		cmd.store_demand = in_fire && op == fms_pkg::OP_DEMAND &&
			mix_mode == fms_pkg::MODE_DEMAND && dcnt_q < nout;
		cmd.div_start = (state_q == ST_MEAN || state_q == ST_FLOW) && !busy_q;
		cmd.load_res = state_q == ST_LOAD;
		cmd.clear = state_q == ST_OUT && out_take && out_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			in_cnt_q <= '0;
			dcnt_q <= '0;
			idx_q <= '0;
			sel_q <= fms_pkg::DSEL_U;
			rd_q <= '0;
			busy_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.accum)
						in_cnt_q <= in_cnt_q + 1'b1;
					if (cmd.store_demand)
						dcnt_q <= dcnt_q + 1'b1;
					if (in_fire && op == fms_pkg::OP_COMPUTE) begin
						state_q <= ST_MEAN;
						sel_q <= fms_pkg::DSEL_U;
						idx_q <= '0;
					end
				end
				ST_MEAN: begin
					if (cmd.div_start)
						busy_q <= 1'b1;
					if (sts.div_done) begin
						busy_q <= 1'b0;
						if (sel_q == fms_pkg::DSEL_T) begin
							state_q <= ST_RD;
							rd_q <= '0;
							sel_q <= fms_pkg::DSEL_FLOW;
						end else
							sel_q <= sel_q + 1'b1;
					end
				end
				ST_RD: begin
					// memory read then product register
					rd_q <= rd_q + 1'b1;
					if (rd_q == 2'd2)
						state_q <= ST_FLOW;
				end
				ST_FLOW: begin
					if (cmd.div_start)
						busy_q <= 1'b1;
					if (sts.div_done) begin
						busy_q <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					valid_q <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_take) begin
						valid_q <= 1'b0;
						if (out_last) begin
							state_q <= ST_IDLE;
							in_cnt_q <= '0;
							dcnt_q <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
							rd_q <= '0;
							state_q <= ST_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### sv/flow_mixer_splitter.sv
// flow mixer and splitter
// s_axis carries requests: op 0 adds an inflow (flow, uranium, acid,
// temperature) to mass-weighted sums, op 1 stores a pump demand for the
// next output (mode 2 only), op 2 computes and emits one result per output.
// op 0 and op 1 leave the block idle, ready for the next request.
// an op 2 request runs a 52-step restoring divider three times for the
// mean uranium, acid and temperature, then once more per output for its
// flow share, after a memory read and a product register; each output
// then has a result load and a handoff.
// m_axis shows one result at a time from an output register; the next
// result is worked out only after the receiver takes the current one, so
// a stall simply holds tvalid and tdata. no request is taken during compute.
// cfg_* writes a register by index; write only while idle.
// reset clears all sums and counters; registers return to one input,
// one output, equal split. the demand memory is not cleared.
module flow_mixer_splitter #(
	parameter int MAX_INPUTS = fms_pkg::MAX_INPUTS_DEF,
	parameter int MAX_OUTPUTS = fms_pkg::MAX_OUTPUTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// op[1:0], flow_rate[25:2], conc_uranium[45:26], conc_acid[65:46],
	// temperature[83:66], demand[107:84]
	input  logic [111:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// output_index[3:0], out_flow[27:4], out_conc_uranium[47:28],
	// out_conc_acid[67:48], out_temperature[85:68], total_demand[109:86]
	output logic [111:0] m_axis_tdata,
	output logic         m_axis_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [4:0]   cfg_data
);
	localparam int CW = $clog2(MAX_OUTPUTS + 1);

	logic [4:0] num_inputs_q, num_outputs_q;
	logic [1:0] mix_mode_q;
	logic [3:0] route_output_q;
	fms_pkg::fms_cmd_t cmd;
	fms_pkg::fms_sts_t sts;
	logic in_fire;
	logic [CW-1:0] dcnt, out_idx, nout;
	logic [23:0] res_flow, res_total;
	logic [19:0] res_u, res_a;
	logic [17:0] res_t;

	assign cfg_ready = 1'b1;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_inputs_q <= 5'd1;
			num_outputs_q <= 5'd1;
			mix_mode_q <= fms_pkg::MODE_EQUAL;
			route_output_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				fms_pkg::REG_NUM_INPUTS: num_inputs_q <= cfg_data;
				fms_pkg::REG_NUM_OUTPUTS: num_outputs_q <= cfg_data;
				fms_pkg::REG_MIX_MODE: mix_mode_q <= cfg_data[1:0];
				fms_pkg::REG_ROUTE_OUTPUT: route_output_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	fms_ctrl #(.MAX_INPUTS(MAX_INPUTS), .MAX_OUTPUTS(MAX_OUTPUTS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .op(s_axis_tdata[1:0]),
		.num_inputs(num_inputs_q), .num_outputs(num_outputs_q),
		.mix_mode(mix_mode_q), .out_take(m_axis_tvalid && m_axis_tready),
		.sts(sts), .cmd(cmd), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_last(m_axis_tlast),
		.demand_count(dcnt), .out_idx(out_idx), .nout(nout)
	);

	fms_datapath #(.MAX_OUTPUTS(MAX_OUTPUTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.flow_rate(s_axis_tdata[25:2]), .conc_uranium(s_axis_tdata[45:26]),
		.conc_acid(s_axis_tdata[65:46]), .temperature(s_axis_tdata[83:66]),
		.demand(s_axis_tdata[107:84]), .demand_idx(dcnt), .out_idx(out_idx),
		.nout(nout), .demand_count(dcnt), .mix_mode(mix_mode_q),
		.route_output(route_output_q), .res_flow(res_flow), .res_u(res_u),
		.res_a(res_a), .res_t(res_t), .res_total(res_total)
	);

	assign m_axis_tdata = {2'b00, res_total, res_t, res_a, res_u, res_flow,
		4'(out_idx)};
endmodule

### sv/fms_checker.sv
module fms_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic         m_axis_tlast,
	input logic [111:0] m_axis_tdata
);
	// no request taken while a result is shown
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("ready during output");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("stalled result changed");
	// a result with zero flow at a nonzero index has a zero uranium mean or zero flow
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[27:4] == '0 && m_axis_tdata[3:0] != '0 |->
		m_axis_tdata[47:28] == '0 || m_axis_tdata[27:4] == '0)
		else $error("means without flow");
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_axis_tready) |-> $past(m_axis_tlast && m_axis_tready))
		else $error("idle without last");
endmodule

bind flow_mixer_splitter fms_checker u_fms_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tlast(m_axis_tlast), .m_axis_tdata(m_axis_tdata)
);
